>>> src/led_bt_pkg.sv
// Package for the LED bit-plane transposer: word types, register codes, plane bit map.
// Used by led_bitplane_transposer; depends on nothing else.
package led_bt_pkg;

    // Fixed geometry
    localparam int ROWS        = 8;
    localparam int PLANE_BITS  = 8;
    localparam int CHANNELS    = 3;
    localparam int PLANES      = PLANE_BITS * CHANNELS;
    localparam int PIX_W       = 24;
    localparam int ROW_IDX_W   = 3;
    localparam int HDR_BYTES   = 4;

    // Configuration port
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 11;
    localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS    = 1'b1;

    // Shift of green, red, blue inside a stored pixel (red<<16 | green<<8 | blue)
    localparam logic [4:0] CHAN_SHIFT [CHANNELS] = '{5'd8, 5'd16, 5'd0};

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_in_word;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       frame_last;
    } t_out_word;

    // Pixel bit that feeds output plane p (G7..G0, R7..R0, B7..B0)
    function automatic logic [4:0] plane_bit(input int p);
        int ch;
        int bt;
        ch = p / PLANE_BITS;
        bt = PLANE_BITS - 1 - (p % PLANE_BITS);
        return CHAN_SHIFT[ch] + 5'(bt);
    endfunction

endpackage

>>> src/led_bitplane_transposer.sv
// LED bit-plane transposer top level: row store memory, gather sweep, plane shifter.
// Depends on led_bt_pkg.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_data) takes one RGB pixel per word,
//   column order: rows 0..rows-1 of column 0, then column 1, and so on.
//   Output channel (o_out_valid / i_out_stall / o_out_data) gives one byte per word.
//   The first pixel of a frame yields a 4-byte big-endian length header (columns*24).
//   The last pixel of a column yields 24 plane bytes: green, red, blue, MSB first,
//   bit y of each byte is row y.
//   Config channel (i_cfg_valid / o_cfg_ready) writes columns_in_use (index 0) and
//   rows_in_use (index 1); ready is always high.
// Timing:
//   Pixels are written straight into an 8-entry row store. At a column end a sweep
//   reads the rows back (one row per cycle, through a registered read port) into a gather
//   buffer, which is copied into a 24-byte plane shifter. Bytes leave the shifter one
//   per cycle while the output is not stalled and no header is pending.
//   With 8 rows the sustained rate is set by the single output port draining 24 bytes
//   per column. A column end waits until the gather buffer is free; a frame start
//   waits until all earlier plane bytes have left the shifter.
// Reset: counters, pending work and config (columns 1, rows 8) are cleared; the row
//   store is not, since a row is always written in its column before it is read.
// Stall: a stalled output holds its word; work backs up and o_in_stall rises.
module led_bitplane_transposer #(
    parameter int MAX_COLUMNS = 1024
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  led_bt_pkg::t_in_word              i_in_data,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output led_bt_pkg::t_out_word             o_out_data,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [led_bt_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [led_bt_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import led_bt_pkg::*;

    // Column limit as seen through the 11-bit register, and counter width
    localparam int MAX_C = (MAX_COLUMNS > 2047) ? 2047 : MAX_COLUMNS;
    localparam int CW    = (MAX_C > 1) ? $clog2(MAX_C) : 1;

    // Config registers
    logic [CFG_DATA_W-1:0] r_cols_cfg;
    logic [3:0]            r_rows_cfg;

    // Position counters
    logic [ROW_IDX_W-1:0]  r_row_cnt;
    logic [CW-1:0]         r_col_cnt;

    // Row store memory and its read port
    logic [PIX_W-1:0]      r_mem [ROWS];
    logic [PIX_W-1:0]      r_rd_data;
    logic                  r_rd_vld;
    logic [ROW_IDX_W-1:0]  r_rd_row;

    // Gather sweep
    logic                  r_gat_busy;
    logic [ROW_IDX_W-1:0]  r_rd_idx;
    logic [ROW_IDX_W-1:0]  r_gat_last;
    logic                  r_gat_full;
    logic                  r_gat_fl;
    logic [7:0]            r_gat [PLANES];

    // Plane shifter
    logic [7:0]            r_emit [PLANES];
    logic [4:0]            r_emit_cnt;
    logic                  r_emit_fl;

    // Header
    logic [2:0]            r_hdr_cnt;
    logic [15:0]           r_hdr_len;
    logic                  r_hdr_rl;

    // Output register
    logic                  r_out_vld;
    t_out_word             r_out;

    // Combinational
    logic [CFG_DATA_W-1:0] eff_cols;
    logic [3:0]            eff_rows;
    logic                  col_end;
    logic                  frame_end;
    logic                  hdr_need;
    logic                  gat_idle;
    logic                  in_acc;
    logic                  out_free;
    logic                  sel_hdr;
    logic                  sel_emit;
    logic                  load;
    logic                  copy;
    t_out_word             n_out;
    logic [15:0]           hdr_len;

    // Effective geometry: zero acts as one, large values saturate
    always_comb begin
        eff_cols = (r_cols_cfg == '0) ? CFG_DATA_W'(1) : r_cols_cfg;
        if (eff_cols > CFG_DATA_W'(MAX_C)) begin
            eff_cols = CFG_DATA_W'(MAX_C);
        end
        eff_rows = (r_rows_cfg == 4'd0) ? 4'd1 : r_rows_cfg;
        if (eff_rows > 4'(ROWS)) begin
            eff_rows = 4'(ROWS);
        end
    end

    assign col_end   = ({1'b0, r_row_cnt} + 4'd1) >= eff_rows;
    assign frame_end = col_end &&
                       ((12'(r_col_cnt) + 12'd1) >= {1'b0, eff_cols});
    assign hdr_need  = (r_row_cnt == '0) && (r_col_cnt == '0);
    assign hdr_len   = (16'(eff_cols) << 4) + (16'(eff_cols) << 3);
    assign gat_idle  = !r_gat_busy && !r_rd_vld && !r_gat_full;

    // Input flow control: column end needs the gather buffer, frame start needs
    // all earlier plane bytes out of the shifter
    assign o_in_stall = (col_end && !gat_idle) ||
                        (hdr_need && (!gat_idle || r_emit_cnt != '0 || r_hdr_cnt != '0));
    assign in_acc     = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    // Output source select: header first, then plane bytes
    always_comb begin
        out_free = !r_out_vld || !i_out_stall;
        sel_hdr  = r_hdr_cnt != '0;
        sel_emit = !sel_hdr && r_emit_cnt != '0;
        load     = out_free && (sel_hdr || sel_emit);
        copy     = r_gat_full &&
                   (r_emit_cnt == '0 || (r_emit_cnt == 5'd1 && load && sel_emit));
        n_out    = '0;
        if (sel_hdr) begin
            case (r_hdr_cnt)
                3'd2:    n_out.out_byte = r_hdr_len[15:8];
                3'd1:    n_out.out_byte = r_hdr_len[7:0];
                default: n_out.out_byte = 8'd0;
            endcase
            n_out.run_last = (r_hdr_cnt == 3'd1) && r_hdr_rl;
        end else begin
            n_out.out_byte   = r_emit[0];
            n_out.run_last   = r_emit_cnt == 5'd1;
            n_out.frame_last = (r_emit_cnt == 5'd1) && r_emit_fl;
        end
    end

    // Config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols_cfg <= CFG_DATA_W'(1);
            r_rows_cfg <= 4'd8;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_COLUMNS: r_cols_cfg <= i_cfg_data;
                CFG_ROWS:    r_rows_cfg <= i_cfg_data[3:0];
                default:     ;
            endcase
        end
    end

    // Row and column counters, header trigger
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_cnt <= '0;
            r_col_cnt <= '0;
            r_hdr_cnt <= '0;
        end else begin
            if (load && sel_hdr) begin
                r_hdr_cnt <= r_hdr_cnt - 3'd1;
            end
            if (in_acc) begin
                if (hdr_need) begin
                    r_hdr_cnt <= 3'(HDR_BYTES);
                end
                if (col_end) begin
                    r_row_cnt <= '0;
                    r_col_cnt <= frame_end ? '0 : r_col_cnt + CW'(1);
                end else begin
                    r_row_cnt <= r_row_cnt + ROW_IDX_W'(1);
                end
            end
        end
    end

    // Header payload
    always_ff @(posedge i_clk) begin
        if (in_acc && hdr_need) begin
            r_hdr_len <= hdr_len;
            r_hdr_rl  <= !col_end;
        end
    end

    // Row store: write on accept, read during the gather sweep (old data on a clash)
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_mem[r_row_cnt] <= {i_in_data.red, i_in_data.green, i_in_data.blue};
        end
        r_rd_data <= r_mem[r_rd_idx];
        r_rd_row  <= r_rd_idx;
    end

    // Gather sweep control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gat_busy <= 1'b0;
            r_rd_idx   <= '0;
            r_rd_vld   <= 1'b0;
            r_gat_full <= 1'b0;
        end else begin
            r_rd_vld <= r_gat_busy;
            if (r_gat_busy) begin
                if (r_rd_idx == r_gat_last) begin
                    r_gat_busy <= 1'b0;
                end else begin
                    r_rd_idx <= r_rd_idx + ROW_IDX_W'(1);
                end
            end
            if (r_rd_vld && r_rd_row == r_gat_last) begin
                r_gat_full <= 1'b1;
            end
            if (copy) begin
                r_gat_full <= 1'b0;
            end
            if (in_acc && col_end) begin
                r_gat_busy <= 1'b1;
                r_rd_idx   <= '0;
            end
        end
    end

    // Gather buffer: transpose each returned row into the 24 plane bytes
    always_ff @(posedge i_clk) begin
        if (in_acc && col_end) begin
            r_gat_last <= 3'(eff_rows - 4'd1);
            r_gat_fl   <= frame_end;
            for (int p = 0; p < PLANES; p++) begin
                r_gat[p] <= '0;
            end
        end
        if (r_rd_vld) begin
            for (int p = 0; p < PLANES; p++) begin
                r_gat[p][r_rd_row] <= r_rd_data[plane_bit(p)];
            end
        end
    end

    // Plane shifter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_emit_cnt <= '0;
        end else if (copy) begin
            r_emit_cnt <= 5'(PLANES);
        end else if (load && sel_emit) begin
            r_emit_cnt <= r_emit_cnt - 5'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (copy) begin
            r_emit    <= r_gat;
            r_emit_fl <= r_gat_fl;
        end else if (load && sel_emit) begin
            for (int p = 0; p < PLANES - 1; p++) begin
                r_emit[p] <= r_emit[p+1];
            end
            r_emit[PLANES-1] <= '0;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (load) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    // Checks
    a_gat_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_gat_full && r_gat_busy))
        else $error("gather buffer full while sweep still running");

    a_emit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_emit_cnt <= 5'(PLANES))
        else $error("plane shifter count out of range");

    a_col_end_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && col_end) |=> (r_gat_busy && !r_gat_full))
        else $error("column end taken while gather buffer in use");

    a_frame_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.frame_last) |-> o_out_data.run_last)
        else $error("frame end byte without run end");

endmodule
